// ===== rtl/mbtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbtc_pkg: shared types and tables for the magic byte type classifier
// Payload structs, result codes and the magic prefix ROM.
// ---------------------------------------------------------------------------
package mbtc_pkg;

    localparam int NUM_ENTRIES      = 40;
    localparam int MAX_PREFIX       = 9;
    localparam int POS_W            = 7;
    localparam int ENTRY_W          = $clog2(NUM_ENTRIES);
    localparam int PIDX_W           = $clog2(MAX_PREFIX);
    localparam int LEN_W            = $clog2(MAX_PREFIX + 1);
    localparam int CODE_W           = 6;
    localparam int TEXT_WINDOW_DEF  = 100;

    localparam logic [CODE_W-1:0] CODE_TEXT = 6'd40;
    localparam logic [CODE_W-1:0] CODE_DATA = 6'd41;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] type_code;
        logic              magic_matched;
    } class_item_t;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] index;
    } match_t;

    localparam logic [LEN_W-1:0] PREFIX_LEN [NUM_ENTRIES] = '{
        4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3,
        4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd3, 4'd9, 4'd5, 4'd5, 4'd1, 4'd3, 4'd3, 4'd2, 4'd2
    };

    localparam logic [7:0] PREFIX_ROM [NUM_ENTRIES][MAX_PREFIX] = '{
        '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hff, 8'hd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h4d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4d, 8'h4d, 8'h00, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4b, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4b, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1f, 8'h8b, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h5a, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfd, 8'h37, 8'h7a, 8'h58, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h28, 8'hb5, 8'h2f, 8'hfd, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1a, 8'h07, 8'h00, 8'h00, 8'h00},
        '{8'h37, 8'h7a, 8'hbc, 8'haf, 8'h27, 8'h1c, 8'h00, 8'h00, 8'h00},
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hd0, 8'hcf, 8'h11, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7f, 8'h45, 8'h4c, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4d, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hca, 8'hfe, 8'hba, 8'hbe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfe, 8'hed, 8'hfa, 8'hce, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfe, 8'hed, 8'hfa, 8'hcf, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hcf, 8'hfa, 8'hed, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hff, 8'hfb, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hff, 8'hf3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4f, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h4c, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1a, 8'h45, 8'hdf, 8'ha3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3c, 8'h21, 8'h44, 8'h4f, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45},
        '{8'h3c, 8'h68, 8'h74, 8'h6d, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3c, 8'h3f, 8'h78, 8'h6d, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hef, 8'hbb, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hff, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfe, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage
`default_nettype wire

// ===== rtl/mbtc_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbtc_match: parallel prefix comparators
// Compares one byte against every prefix at the current position, updates
// the per-entry alive bits and picks the lowest fully matched entry.
// ---------------------------------------------------------------------------
module mbtc_match (
    input  wire logic [mbtc_pkg::POS_W-1:0]       pos,
    input  wire logic [7:0]                       data_byte,
    input  wire logic [mbtc_pkg::NUM_ENTRIES-1:0] alive,
    output logic      [mbtc_pkg::NUM_ENTRIES-1:0] alive_next,
    output mbtc_pkg::match_t                      match
);
    import mbtc_pkg::*;

    logic [PIDX_W-1:0]  pidx;
    logic [POS_W:0]     count;
    logic [NUM_ENTRIES-1:0] full;

    assign pidx  = (pos < POS_W'(MAX_PREFIX)) ? pos[PIDX_W-1:0] : '0;
    assign count = {1'b0, pos} + (POS_W+1)'(1);

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if ((pos < POS_W'(PREFIX_LEN[i])) && (PREFIX_ROM[i][pidx] != data_byte))
                alive_next[i] = 1'b0;
            else
                alive_next[i] = alive[i];
            full[i] = alive_next[i] && ((POS_W+1)'(PREFIX_LEN[i]) <= count);
        end
    end

    // lowest index wins
    always_comb
    begin
        match.hit   = 1'b0;
        match.index = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (full[i])
            begin
                match.hit   = 1'b1;
                match.index = ENTRY_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/magic_byte_type_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// magic_byte_type_classifier: stream file type detection by magic prefix
// Classifies a byte stream by its leading bytes, or as text or data.
// ---------------------------------------------------------------------------
//  channel   | signals                            | transfer carries
//  ----------+------------------------------------+---------------------------
//  byte      | byte_valid, byte_stall, byte_item  | one stream byte, last flag
//  class     | class_valid, class_stall, class_item | type code, magic flag
//
//  One byte per cycle while no final byte waits on a stalled result. A byte
//  passes an input register, then the comparator bank updates the stream
//  state; the final byte also loads the result register. Reset clears the
//  stream state and both valid flags. A stalled result holds only final
//  bytes behind it; other bytes keep flowing.
// ---------------------------------------------------------------------------
module magic_byte_type_classifier #(
    parameter int TEXT_WINDOW = mbtc_pkg::TEXT_WINDOW_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire mbtc_pkg::byte_item_t  byte_item,
    output logic                       class_valid,
    input  wire logic                  class_stall,
    output mbtc_pkg::class_item_t      class_item
);
    import mbtc_pkg::*;

    localparam logic [POS_W-1:0] WINDOW = POS_W'(TEXT_WINDOW);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic                   s1_valid_reg;
    byte_item_t             s1_item_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [NUM_ENTRIES-1:0] alive_reg;
    logic [NUM_ENTRIES-1:0] alive_next;
    logic                   printable_reg;
    logic                   printable_next;
    logic                   out_valid_reg;
    class_item_t            out_item_reg;
    class_item_t            out_item_next;
    match_t                 match;
    logic                   out_free;
    logic                   s1_move;
    logic                   s1_load;
    logic                   ctrl_byte;

    mbtc_match u_match (
        .pos        (pos_reg),
        .data_byte  (s1_item_reg.data_byte),
        .alive      (alive_reg),
        .alive_next (alive_next),
        .match      (match)
    );

    assign out_free   = !out_valid_reg || !class_stall;
    assign s1_move    = s1_valid_reg && (!s1_item_reg.last_byte || out_free);
    assign byte_stall = s1_valid_reg && !s1_move;
    assign s1_load    = byte_valid && !byte_stall;

    assign ctrl_byte = (s1_item_reg.data_byte < CHAR_SPACE)
                    && (s1_item_reg.data_byte != CHAR_TAB)
                    && (s1_item_reg.data_byte != CHAR_LF)
                    && (s1_item_reg.data_byte != CHAR_CR);

    assign printable_next = printable_reg && !((pos_reg < WINDOW) && ctrl_byte);
    assign pos_next       = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

    always_comb
    begin
        if (match.hit)
        begin
            out_item_next.type_code     = CODE_W'(match.index);
            out_item_next.magic_matched = 1'b1;
        end
        else
        begin
            out_item_next.type_code     = printable_next ? CODE_TEXT : CODE_DATA;
            out_item_next.magic_matched = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            alive_reg     <= '1;
            printable_reg <= 1'b1;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move && s1_item_reg.last_byte)
                out_valid_reg <= 1'b1;
            else if (!class_stall)
                out_valid_reg <= 1'b0;

            if (s1_move)
            begin
                if (s1_item_reg.last_byte)
                begin
                    pos_reg       <= '0;
                    alive_reg     <= '1;
                    printable_reg <= 1'b1;
                end
                else
                begin
                    pos_reg       <= pos_next;
                    alive_reg     <= alive_next;
                    printable_reg <= printable_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_item_reg <= byte_item;
        if (s1_move && s1_item_reg.last_byte)
            out_item_reg <= out_item_next;
    end

    assign class_valid = out_valid_reg;
    assign class_item  = out_item_reg;

endmodule
`default_nettype wire
